### sv/modular_exponentiation_defines.svh
// Assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Check cons in the same cycle as ante
`define MEXP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define MEXP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mexp_pkg.sv
// Shared constants, codes and types of the modular exponentiation block
package mexp_pkg;

    localparam int DATA_W        = 32;
    localparam int WIDTH_DEFAULT = 32;
    localparam int CFG_INDEX_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = CFG_INDEX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_SQUARE,
        ST_FINISH
    } mexp_state_t;

    typedef enum logic [1:0] {
        MSEL_REDUCE,
        MSEL_ACC,
        MSEL_SQUARE
    } mexp_msel_t;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        mexp_msel_t mul_sel;
        logic       wr_power;
        logic       wr_acc;
        logic       shift_exp;
        logic       load_out;
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic mul_busy;
        logic exp_zero;
        logic exp_lsb;
    } mexp_sts_t;

endpackage

### sv/mexp_mulmod.sv
// Shift-add modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic             busy,
    output logic [WIDTH-1:0] prod
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH+1:0] n_ext;
    logic [WIDTH+1:0] dbl;
    logic [WIDTH+1:0] red1;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] red2;

    // zero modulus stands for 2^WIDTH
    assign n_ext = {1'b0, (modulus == '0), modulus};
    assign dbl   = {1'b0, r_reg, 1'b0};
    assign red1  = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
    assign sum   = red1 + (b_reg[WIDTH-1] ? {2'b00, a_reg} : '0);
    assign red2  = (sum >= n_ext) ? (sum - n_ext) : sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            r_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
            r_reg <= red2[WIDTH-1:0];
        end
    end

    assign done = done_reg;
    assign busy = busy_reg;
    assign prod = r_reg;

endmodule

### sv/mexp_datapath.sv
// Operand registers, exponent shifter and result register around the multiplier
module mexp_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mexp_pkg::mexp_cmd_t cmd,
    output mexp_pkg::mexp_sts_t sts,
    input  logic [WIDTH-1:0]    base_value,
    input  logic [WIDTH-1:0]    modulus,
    input  logic [WIDTH-1:0]    exponent,
    output logic [WIDTH-1:0]    result
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] power_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] res_reg;

    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_prod;
    logic             mul_done;
    logic             mul_busy;

    always_comb begin
        unique case (cmd.mul_sel)
            MSEL_REDUCE: begin
                mul_a = WIDTH'(1);
                mul_b = base_value;
            end
            MSEL_ACC: begin
                mul_a = power_reg;
                mul_b = acc_reg;
            end
            MSEL_SQUARE: begin
                mul_a = power_reg;
                mul_b = power_reg;
            end
            default: begin
                mul_a = power_reg;
                mul_b = power_reg;
            end
        endcase
    end

    mexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .modulus(modulus),
        .done   (mul_done),
        .busy   (mul_busy),
        .prod   (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= WIDTH'(1);
            exp_reg <= exponent;
        end else begin
            if (cmd.wr_acc) begin
                acc_reg <= mul_prod;
            end
            if (cmd.shift_exp) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.wr_power) begin
            power_reg <= mul_prod;
        end
        if (cmd.load_out) begin
            res_reg <= acc_reg;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.mul_busy = mul_busy;
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_lsb  = exp_reg[0];
    assign result       = res_reg;

endmodule

### sv/mexp_ctrl.sv
// Sequencer for the square-and-multiply loop and the result handshake
module mexp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t cmd
);
    import mexp_pkg::*;

    mexp_state_t state_reg;
    mexp_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MSEL_SQUARE;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_REDUCE;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sts.mul_done) begin
                    cmd.wr_power = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.exp_zero) begin
                    state_next = ST_FINISH;
                end else if (sts.exp_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_ACC;
                    state_next    = ST_MUL_ACC;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_SQUARE;
                end
            end
            ST_MUL_ACC: begin
                if (sts.mul_done) begin
                    cmd.wr_acc    = 1'b1;
                    cmd.mul_start = 1'b1;
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (sts.mul_done) begin
                    cmd.wr_power  = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### sv/modular_exponentiation.sv
// Top level of the modular exponentiation block: configuration and assembly
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_base_value
//  m_       out        m_valid / m_ready    m_power_result
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wr_data
//
// One word at a time on a shared shift-add multiplier. An accepted word is first
// reduced by the modulus; then each exponent bit up to the highest set one takes a
// square, preceded by a multiply into the accumulator for each set bit. s_ready
// rises with m_valid. Synchronous active-low reset; modulus and exponent reset to 1.
// A finished word waits in the output register while the next word is taken; the
// one after holds until m_ready frees the register.
module modular_exponentiation #(
    parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mexp_pkg::DATA_W-1:0]      cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mexp_pkg::DATA_W-1:0]      s_base_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mexp_pkg::DATA_W-1:0]      m_power_result
);
    import mexp_pkg::*;

    `include "modular_exponentiation_defines.svh"

    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic [WIDTH-1:0] result;
    mexp_cmd_t        cmd;
    mexp_sts_t        sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= WIDTH'(1);
            exponent_reg <= WIDTH'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODULUS:  modulus_reg  <= cfg_wr_data[WIDTH-1:0];
                REG_EXPONENT: exponent_reg <= cfg_wr_data[WIDTH-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    mexp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    mexp_datapath #(
        .WIDTH(WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .base_value(s_base_value[WIDTH-1:0]),
        .modulus   (modulus_reg),
        .exponent  (exponent_reg),
        .result    (result)
    );

    assign m_power_result = DATA_W'(result);

    `MEXP_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "ready after accept")
    `MEXP_ASSERT_NOW(a_valid_rise, aclk, aresetn, $rose(m_valid), !$past(s_ready), "stray result")
    `MEXP_ASSERT_NOW(a_mul_free, aclk, aresetn, cmd.mul_start, !sts.mul_busy, "start while busy")
    `MEXP_ASSERT_NOW(a_hold_out, aclk, aresetn, cmd.load_out, !m_valid || m_ready, "overwrite")

endmodule
